// ===== hw/rtl/raft_leader_replication_tracker_unit_assert.svh =====
// Assertion macros shared by the tracker RTL.
// Each macro expects clk and arst_n in scope.
`ifndef RAFT_LEADER_REPLICATION_TRACKER_UNIT_ASSERT_SVH
`define RAFT_LEADER_REPLICATION_TRACKER_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define RLRT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define RLRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Check cond at every edge out of reset.
`define RLRT_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

// ===== hw/rtl/rlrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rlrt_pkg;

	localparam int NODES_DEF         = 8;
	localparam int LOG_DEPTH_DEF     = 1024;
	localparam int RETRANS_DEPTH_DEF = 8;

	localparam logic signed [31:0] IDX_NONE = -32'sd1;
	localparam logic signed [31:0] IDX_MAX  = 32'sh7fffffff;

	typedef enum logic [2:0] {
		ACT_START   = 3'd0,
		ACT_APPEND  = 3'd1,
		ACT_REPLY   = 3'd2,
		ACT_ALIVE   = 3'd3,
		ACT_LIVE    = 3'd4,
		ACT_POP     = 3'd5,
		ACT_STOP    = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		RS_FAIL = 2'd0,
		RS_OK   = 2'd1,
		RS_RETX = 2'd2
	} reply_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_FAULT      = 3'd1,
		ST_FULL       = 3'd2,
		ST_DUP        = 3'd3,
		ST_NOT_LEADER = 3'd4
	} status_t;

	localparam logic CFG_FOLLOWERS = 1'b0;
	localparam logic CFG_TERM      = 1'b1;

	// Next index from an index: v + 1 clamped to 0..2^31-1.
	function automatic logic [30:0] sat_next(input logic signed [31:0] v);
		logic signed [32:0] s;
		s = $signed({v[31], v}) + 33'sd1;
		if (s < 33'sd0)
			return 31'd0;
		else if (s > 33'sd2147483647)
			return 31'h7fffffff;
		else
			return s[30:0];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rlrt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rlrt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/rlrt_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Remainder of a value below 2^31 by a constant: a mask for powers of two,
// otherwise a reciprocal multiplication with registered steps (quotient,
// then value minus quotient times divisor).
module rlrt_mod #(
	parameter int DIVISOR = 1024,
	localparam int RW = $clog2(DIVISOR)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [31:0]   value,
	output logic               done,
	output logic      [RW-1:0] rem
);

	localparam bit IS_POW2 = (DIVISOR & (DIVISOR - 1)) == 0;

	logic          done_q;
	logic [RW-1:0] rem_q;

	generate
		if (IS_POW2) begin : g_mask
			// Take the low bits
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					done_q <= 1'b0;
				else
					done_q <= start;
			end
			always_ff @(posedge clk) begin
				if (start)
					rem_q <= value[RW-1:0];
			end
		end else begin : g_recip
			localparam int SHIFT = 31 + RW;
			localparam logic [31:0] MAGIC =
				32'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
			localparam logic [31:0] DIV_W = 32'(DIVISOR);
			logic        valid_s1;
			logic [30:0] x_s1;
			logic [31:0] quo_s1;
			logic [62:0] prod;
			logic [31:0] back;
			logic [31:0] diff;

			assign prod = 63'(value[30:0]) * 63'(MAGIC);
			assign back = quo_s1 * DIV_W;
			assign diff = {1'b0, x_s1} - back;

			// Quotient register first, then the remainder register
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s1 <= 1'b0;
					done_q   <= 1'b0;
				end else begin
					valid_s1 <= start;
					done_q   <= valid_s1;
				end
			end
			always_ff @(posedge clk) begin
				if (start) begin
					x_s1   <= value[30:0];
					quo_s1 <= 32'(prod >> SHIFT);
				end
				if (valid_s1)
					rem_q <= diff[RW-1:0];
			end
		end
	endgenerate

	assign done = done_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

// ===== hw/rtl/raft_leader_replication_tracker_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Leader-side replication tracker: one result per accepted item, in order.
// Each item is latched, executed and loaded into the output register; a local
// append also waits for the remainder unit (a mask when LOG_DEPTH is a power
// of two, a reciprocal multiplication otherwise). A success reply walks the
// used followers one after another, each step being a remainder plus one term
// memory read, stopping at the first unusable match. A retransmit request
// scans the target's queue with a read and a compare per queued index; a pop
// reads the queue head. The term memory and the retransmit memory hold no
// reset value and need no clearing pass; the block is ready right after reset.
module raft_leader_replication_tracker_unit #(
	parameter int NODES         = rlrt_pkg::NODES_DEF,
	parameter int LOG_DEPTH     = rlrt_pkg::LOG_DEPTH_DEF,
	parameter int RETRANS_DEPTH = rlrt_pkg::RETRANS_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [0:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	// input items
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         action,
	input  wire logic [2:0]         target,
	input  wire logic [1:0]         reply_status,
	input  wire logic signed [31:0] follower_last,
	input  wire logic signed [31:0] follower_match,
	input  wire logic [30:0]        message_term,
	input  wire logic               alive_flag,
	input  wire logic signed [31:0] start_index,
	// results
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      commit_index,
	output logic                    commit_changed,
	output logic [30:0]             target_next_index,
	output logic                    step_down,
	output logic [30:0]             seen_term,
	output logic                    retrans_valid,
	output logic signed [31:0]      retrans_index,
	output logic [2:0]              status
);

	localparam int IW  = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int CW  = $clog2(NODES + 1);
	localparam int QW  = (RETRANS_DEPTH > 1) ? $clog2(RETRANS_DEPTH) : 1;
	localparam int PW  = $clog2(RETRANS_DEPTH + 1);
	localparam int QAW = (NODES * RETRANS_DEPTH > 1) ? $clog2(NODES * RETRANS_DEPTH) : 1;
	localparam int RW  = $clog2(LOG_DEPTH);
	localparam logic [QW:0] RD_W = (QW+1)'(RETRANS_DEPTH);
	localparam logic [PW-1:0] RD_P = PW'(RETRANS_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_AMOD, S_CAND, S_CMOD, S_CRD, S_CFIN,
		S_QRD, S_QCHK, S_QEND, S_PRD, S_PDAT, S_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [3:0]  fc_q;
	logic [30:0] term_q;

	// latched item
	logic [2:0]         act_q;
	logic [2:0]         tgt_q;
	logic [1:0]         rs_q;
	logic signed [31:0] flast_q;
	logic signed [31:0] fmatch_q;
	logic [30:0]        mterm_q;
	logic               aflag_q;
	logic signed [31:0] sidx_q;

	// tracker state
	logic signed [31:0] match_q [NODES];
	logic [30:0]        next_q  [NODES];
	logic [PW-1:0]      pend_q  [NODES];
	logic [QW-1:0]      head_q  [NODES];
	logic [NODES-1:0]   alive_q;
	logic signed [31:0] last_q;
	logic signed [31:0] commit_q;
	logic               leading_q;

	// walk state
	logic [CW-1:0]      i_q;
	logic [PW-1:0]      j_q;
	logic signed [31:0] cand_q;
	logic               am_q;
	logic signed [31:0] best_q;

	// result being built
	logic         r_changed_q;
	logic         r_sd_q;
	logic [30:0]  r_sterm_q;
	logic         r_rvalid_q;
	logic [31:0]  r_ridx_q;
	logic [2:0]   r_status_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] o_commit_q;
	logic               o_changed_q;
	logic [30:0]        o_next_q;
	logic               o_sd_q;
	logic [30:0]        o_sterm_q;
	logic               o_rvalid_q;
	logic [31:0]        o_ridx_q;
	logic [2:0]         o_status_q;

	// memories and remainder unit
	logic          mod_start;
	logic [31:0]   mod_value;
	logic          mod_done;
	logic [RW-1:0] mod_rem;
	logic          term_we;
	logic [30:0]   term_rdata;
	logic          q_we;
	logic [QAW-1:0] q_waddr;
	logic [QAW-1:0] q_raddr;
	logic [31:0]   q_rdata;

	// decode helpers
	logic [CW-1:0]      n_used;
	logic               tvalid;
	logic [IW-1:0]      tix;
	logic [IW-1:0]      iix;
	logic signed [31:0] cur_match;
	logic               all_match;
	logic               flast_ok;
	logic               fmatch_ok;
	logic [QW:0]        rd_sum;
	logic [QW:0]        wr_sum;
	logic [QW:0]        hd_sum;
	logic [QW-1:0]      slot_rd;
	logic [QW-1:0]      slot_wr;
	logic [QW-1:0]      head_inc;

	assign tix = IW'(tgt_q);
	assign iix = i_q[IW-1:0];

	// Clamp the follower count to 1..NODES
	always_comb begin
		logic [5:0] fc6;
		fc6 = 6'(fc_q);
		if (fc6 == 6'd0)
			n_used = CW'(1);
		else if (fc6 > 6'(NODES))
			n_used = CW'(NODES);
		else
			n_used = CW'(fc6);
	end

	assign tvalid = 6'(tgt_q) < 6'(n_used);

	assign flast_ok  = (flast_q >= rlrt_pkg::IDX_NONE) && (flast_q <= last_q);
	assign fmatch_ok = (fmatch_q >= rlrt_pkg::IDX_NONE) && (fmatch_q <= last_q);

	// Candidate and its all-follower match check
	assign cur_match = match_q[iix];
	always_comb begin
		all_match = 1'b1;
		for (int k = 0; k < NODES; k++) begin
			if ((CW'(k) < n_used) && alive_q[k] && (match_q[k] < cur_match))
				all_match = 1'b0;
		end
	end

	// Queue slots, wrapped at the queue depth
	always_comb begin
		rd_sum = {1'b0, head_q[tix]} + (QW+1)'(j_q);
		wr_sum = {1'b0, head_q[tix]} + (QW+1)'(pend_q[tix]);
		hd_sum = {1'b0, head_q[tix]} + (QW+1)'(1);
		slot_rd  = (rd_sum >= RD_W) ? QW'(rd_sum - RD_W) : QW'(rd_sum);
		slot_wr  = (wr_sum >= RD_W) ? QW'(wr_sum - RD_W) : QW'(wr_sum);
		head_inc = (hd_sum >= RD_W) ? QW'(hd_sum - RD_W) : QW'(hd_sum);
	end

	assign q_raddr = QAW'(int'(tix) * RETRANS_DEPTH + int'(slot_rd));
	assign q_waddr = QAW'(int'(tix) * RETRANS_DEPTH + int'(slot_wr));
	assign q_we    = (state_q == S_QEND) && (pend_q[tix] < RD_P);

	// Remainder requests: new log slot on append, candidate slot on commit walk
	assign mod_start = ((state_q == S_EXEC) && (act_q == rlrt_pkg::ACT_APPEND)
	                    && (last_q != rlrt_pkg::IDX_MAX))
	                || ((state_q == S_CAND) && (cur_match >= 32'sd0)
	                    && (cur_match <= last_q));
	assign mod_value = (state_q == S_CAND) ? 32'(cur_match) : 32'(last_q + 32'sd1);
	assign term_we   = (state_q == S_AMOD) && mod_done;

	rlrt_mod #(
		.DIVISOR (LOG_DEPTH)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.value  (mod_value),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	rlrt_ram #(
		.WIDTH (31),
		.DEPTH (LOG_DEPTH)
	) u_term_ram (
		.clk   (clk),
		.we    (term_we),
		.waddr (mod_rem),
		.wdata (mterm_q),
		.raddr (mod_rem),
		.rdata (term_rdata)
	);

	rlrt_ram #(
		.WIDTH (32),
		.DEPTH (NODES * RETRANS_DEPTH)
	) u_retx_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (32'(flast_q)),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	// Configuration writes
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q   <= 4'd1;
			term_q <= 31'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rlrt_pkg::CFG_FOLLOWERS: fc_q   <= cfg_data[3:0];
				rlrt_pkg::CFG_TERM:      term_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Sequencer: state, tracker registers and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			for (int k = 0; k < NODES; k++) begin
				match_q[k] <= rlrt_pkg::IDX_NONE;
				next_q[k]  <= 31'd0;
				pend_q[k]  <= '0;
				head_q[k]  <= '0;
			end
			alive_q   <= '1;
			last_q    <= rlrt_pkg::IDX_NONE;
			commit_q  <= rlrt_pkg::IDX_NONE;
			leading_q <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_DONE))
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q       <= action;
						tgt_q       <= target;
						rs_q        <= reply_status;
						flast_q     <= follower_last;
						fmatch_q    <= follower_match;
						mterm_q     <= message_term;
						aflag_q     <= alive_flag;
						sidx_q      <= start_index;
						r_changed_q <= 1'b0;
						r_sd_q      <= 1'b0;
						r_sterm_q   <= 31'd0;
						r_rvalid_q  <= 1'b0;
						r_ridx_q    <= 32'(rlrt_pkg::IDX_NONE);
						r_status_q  <= rlrt_pkg::ST_OK;
						state_q     <= S_EXEC;
					end
				end

				S_EXEC: begin
					state_q <= S_DONE;
					unique case (act_q)
						rlrt_pkg::ACT_START: begin
							for (int k = 0; k < NODES; k++) begin
								next_q[k]  <= rlrt_pkg::sat_next(sidx_q);
								match_q[k] <= rlrt_pkg::IDX_NONE;
								pend_q[k]  <= '0;
							end
							leading_q <= 1'b1;
						end
						rlrt_pkg::ACT_APPEND: begin
							if (last_q == rlrt_pkg::IDX_MAX)
								r_status_q <= rlrt_pkg::ST_FAULT;
							else
								state_q <= S_AMOD;
						end
						rlrt_pkg::ACT_REPLY: begin
							if (!leading_q)
								r_status_q <= rlrt_pkg::ST_NOT_LEADER;
							else if (!tvalid)
								r_status_q <= rlrt_pkg::ST_FAULT;
							else begin
								case (rs_q)
									rlrt_pkg::RS_FAIL: begin
										if (!flast_ok)
											r_status_q <= rlrt_pkg::ST_FAULT;
										else
											next_q[tix] <= rlrt_pkg::sat_next(flast_q);
									end
									rlrt_pkg::RS_OK: begin
										if (!fmatch_ok)
											r_status_q <= rlrt_pkg::ST_FAULT;
										else begin
											match_q[tix] <= fmatch_q;
											i_q          <= '0;
											best_q       <= rlrt_pkg::IDX_NONE;
											state_q      <= S_CAND;
										end
									end
									rlrt_pkg::RS_RETX: begin
										if (!fmatch_ok || !flast_ok)
											r_status_q <= rlrt_pkg::ST_FAULT;
										else begin
											j_q     <= '0;
											state_q <= (pend_q[tix] == '0) ? S_QEND : S_QRD;
										end
									end
									default: r_status_q <= rlrt_pkg::ST_FAULT;
								endcase
							end
						end
						rlrt_pkg::ACT_ALIVE: begin
							if (!leading_q)
								r_status_q <= rlrt_pkg::ST_NOT_LEADER;
							else if (mterm_q > term_q) begin
								r_sd_q    <= 1'b1;
								r_sterm_q <= mterm_q;
								leading_q <= 1'b0;
							end
						end
						rlrt_pkg::ACT_LIVE: begin
							if (!tvalid)
								r_status_q <= rlrt_pkg::ST_FAULT;
							else
								alive_q[tix] <= aflag_q;
						end
						rlrt_pkg::ACT_POP: begin
							if (!leading_q)
								r_status_q <= rlrt_pkg::ST_NOT_LEADER;
							else if (!tvalid)
								r_status_q <= rlrt_pkg::ST_FAULT;
							else if (pend_q[tix] != '0) begin
								j_q     <= '0;
								state_q <= S_PRD;
							end
						end
						rlrt_pkg::ACT_STOP: begin
							for (int k = 0; k < NODES; k++)
								pend_q[k] <= '0;
							leading_q <= 1'b0;
						end
						default: r_status_q <= rlrt_pkg::ST_FAULT;
					endcase
				end

				// Wait for the log slot, then record the term
				S_AMOD: begin
					if (mod_done) begin
						last_q  <= last_q + 32'sd1;
						state_q <= S_DONE;
					end
				end

				// Take the next candidate, or give up on an unusable match
				S_CAND: begin
					if ((cur_match < 32'sd0) || (cur_match > last_q))
						state_q <= S_DONE;
					else begin
						cand_q  <= cur_match;
						am_q    <= all_match;
						state_q <= S_CMOD;
					end
				end

				S_CMOD: begin
					if (mod_done)
						state_q <= S_CRD;
				end

				// Term memory data is here: keep the best qualifying candidate
				S_CRD: begin
					if ((term_rdata == term_q) && am_q && (cand_q > best_q))
						best_q <= cand_q;
					if (i_q + CW'(1) == n_used)
						state_q <= S_CFIN;
					else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_CAND;
					end
				end

				S_CFIN: begin
					if (commit_q < best_q) begin
						commit_q    <= best_q;
						r_changed_q <= 1'b1;
					end
					state_q <= S_DONE;
				end

				S_QRD: state_q <= S_QCHK;

				// Compare one queued index against the request
				S_QCHK: begin
					if (q_rdata == 32'(flast_q)) begin
						r_status_q <= rlrt_pkg::ST_DUP;
						state_q    <= S_DONE;
					end else if (j_q + PW'(1) == pend_q[tix])
						state_q <= S_QEND;
					else begin
						j_q     <= j_q + PW'(1);
						state_q <= S_QRD;
					end
				end

				S_QEND: begin
					if (pend_q[tix] >= RD_P)
						r_status_q <= rlrt_pkg::ST_FULL;
					else
						pend_q[tix] <= pend_q[tix] + PW'(1);
					state_q <= S_DONE;
				end

				S_PRD: state_q <= S_PDAT;

				// Hand out the queue head and advance it
				S_PDAT: begin
					r_rvalid_q   <= 1'b1;
					r_ridx_q     <= q_rdata;
					head_q[tix]  <= head_inc;
					pend_q[tix]  <= pend_q[tix] - PW'(1);
					state_q      <= S_DONE;
				end

				// Load the output register once it is free
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						o_commit_q  <= commit_q;
						o_changed_q <= r_changed_q;
						o_next_q    <= tvalid ? next_q[tix] : 31'd0;
						o_sd_q      <= r_sd_q;
						o_sterm_q   <= r_sterm_q;
						o_rvalid_q  <= r_rvalid_q;
						o_ridx_q    <= r_ridx_q;
						o_status_q  <= r_status_q;
						state_q     <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready          = (state_q == S_IDLE);
	assign out_valid         = out_valid_q;
	assign commit_index      = o_commit_q;
	assign commit_changed    = o_changed_q;
	assign target_next_index = o_next_q;
	assign step_down         = o_sd_q;
	assign seen_term         = o_sterm_q;
	assign retrans_valid     = o_rvalid_q;
	assign retrans_index     = $signed(o_ridx_q);
	assign status            = o_status_q;

`include "raft_leader_replication_tracker_unit_assert.svh"

	`RLRT_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
	`RLRT_ASSERT_NEXT(a_commit_idle, state_q == S_IDLE, $stable(commit_q), "commit moved while idle")
	`RLRT_ASSERT_ALWAYS(a_pend_bound, pend_q[0] <= RD_P, "retransmit queue overfilled")
	`RLRT_ASSERT_IMPLIES(a_mod_owner, mod_done, state_q == S_AMOD || state_q == S_CMOD, "stray remainder")

endmodule
`default_nettype wire
